// File: src/mhi_pkg.sv
// ----------------------------------------------------------------------------
// mhi_pkg
// Shared constants and types for the hard-iron min/max calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

package mhi_pkg;

   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_ALPHA     = 1'd1;

   localparam logic [CSR_W-1:0] SPAN_THRESHOLD_RST = 16'd128;
   localparam logic [CSR_W-1:0] BIAS_ALPHA_RST     = 16'd1311;

   typedef struct packed {
      logic go;
      logic load_mid;
      logic refine;
      logic apply;
   } mhi_ctrl_type;

endpackage

`default_nettype wire

// File: src/mhi_req_if.sv
// ----------------------------------------------------------------------------
// mhi_req_if
// Sample channel: valid/ready handshake with a three-axis raw sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhi_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] mag_x;
   logic signed [SAMPLE_BITS-1:0] mag_y;
   logic signed [SAMPLE_BITS-1:0] mag_z;

   modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
   modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

`default_nettype wire

// File: src/mhi_rsp_if.sv
// ----------------------------------------------------------------------------
// mhi_rsp_if
// Result channel: valid/ready handshake with the corrected sample and flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhi_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_x;
   logic signed [SAMPLE_BITS-1:0] out_y;
   logic signed [SAMPLE_BITS-1:0] out_z;
   logic                          calibrated;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output calibrated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input calibrated, output ready);
endinterface

`default_nettype wire

// File: src/mhi_axis.sv
// ----------------------------------------------------------------------------
// mhi_axis
// One axis: running min/max, span check, bias load/refine and correction.
// ----------------------------------------------------------------------------
`default_nettype none

module mhi_axis import mhi_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mhi_ctrl_type                  ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic        [CSR_W-1:0]       span_threshold,
   input  wire logic        [CSR_W-1:0]       bias_alpha,
   output logic                               span_ok,
   output logic signed [SAMPLE_BITS-1:0]      result
);

   localparam int SB     = SAMPLE_BITS;
   localparam int BW     = SB + 17;
   localparam int SPAN_W = ((SB > CSR_W) ? SB : CSR_W) + 2;

   localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

   logic signed [SB-1:0]     min_ff, min_in;
   logic signed [SB-1:0]     max_ff, max_in;
   logic signed [BW-1:0]     bias_ff, bias_in;
   logic signed [SPAN_W-1:0] span;
   logic signed [SPAN_W-1:0] thr_ext;
   logic signed [SB:0]       mid_sum;
   logic signed [BW-1:0]     mid;
   logic signed [BW:0]       diff;
   logic signed [BW+17:0]    prod;
   logic signed [BW:0]       step;
   logic signed [BW:0]       bias_sum;
   logic signed [BW:0]       rnd;
   logic signed [SB+1:0]     applied;
   logic signed [SB+2:0]     corr;
   logic signed [SB-1:0]     sat;

   always_comb begin
      min_in   = (sample < min_ff) ? sample : min_ff;
      max_in   = (sample > max_ff) ? sample : max_ff;
      span     = {{(SPAN_W-SB){max_in[SB-1]}}, max_in} - {{(SPAN_W-SB){min_in[SB-1]}}, min_in};
      thr_ext  = {{(SPAN_W-CSR_W){1'b0}}, span_threshold};
      span_ok  = span > thr_ext;

      mid_sum  = {max_in[SB-1], max_in} + {min_in[SB-1], min_in};
      mid      = {mid_sum[SB], mid_sum, 15'd0};
      diff     = {mid[BW-1], mid} - {bias_ff[BW-1], bias_ff};
      prod     = diff * $signed({1'b0, bias_alpha});
      step     = prod[BW+16:16];
      bias_sum = {bias_ff[BW-1], bias_ff} + step;

      if (ctrl.load_mid) begin
         bias_in = mid;
      end else if (ctrl.refine) begin
         bias_in = bias_sum[BW-1:0];
      end else begin
         bias_in = bias_ff;
      end

      rnd     = {bias_in[BW-1], bias_in} + {{(BW-15){1'b0}}, 16'h8000};
      applied = rnd[BW:16];
      corr    = {{3{sample[SB-1]}}, sample} - {applied[SB+1], applied};
      if (corr > $signed({{3{SMAX[SB-1]}}, SMAX})) begin
         sat = SMAX;
      end else if (corr < $signed({{3{SMIN[SB-1]}}, SMIN})) begin
         sat = SMIN;
      end else begin
         sat = corr[SB-1:0];
      end
      result = ctrl.apply ? sat : sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= SMAX;
         max_ff  <= SMIN;
         bias_ff <= '0;
      end else if (ctrl.go) begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         bias_ff <= bias_in;
      end
   end

endmodule

`default_nettype wire

// File: src/mag_hard_iron_autocal_core.sv
// ----------------------------------------------------------------------------
// mag_hard_iron_autocal_core
// Hard-iron calibration by per-axis running min/max with bias refinement.
// ----------------------------------------------------------------------------
// Result path: an accepted item passes through the input register, then the result register.
// Throughput: 1 item per cycle unless rsp_if.ready stalls it; the bias update chain
// (one multiply per axis) sits in the single stage between input and result register.
// Reset: synchronous, sets min/max to their extremes, clears bias/flag and loads register defaults.
`default_nettype none

module mag_hard_iron_autocal_core import mhi_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   mhi_req_if.sink                   req_if,
   mhi_rsp_if.source                 rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int SB = SAMPLE_BITS;

   logic                 in_valid_ff;
   logic signed [SB-1:0] in_x_ff, in_y_ff, in_z_ff;
   logic                 rsp_valid_ff;
   logic signed [SB-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                 calib_ff, calib_in;
   logic                 cal_out_ff;
   logic [CSR_W-1:0]     thr_ff, alpha_ff;
   logic                 stage_go;
   logic                 span_x, span_y, span_z, all_span;
   logic signed [SB-1:0] res_x, res_y, res_z;
   mhi_ctrl_type         ctrl;

   assign stage_go     = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || stage_go;
   assign all_span     = span_x && span_y && span_z;
   assign calib_in     = calib_ff || all_span;

   always_comb begin
      ctrl.go       = stage_go;
      ctrl.load_mid = !calib_ff && all_span;
      ctrl.refine   = calib_ff;
      ctrl.apply    = calib_in;
   end

   mhi_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
      .clock, .reset, .ctrl, .sample(in_x_ff), .span_threshold(thr_ff),
      .bias_alpha(alpha_ff), .span_ok(span_x), .result(res_x)
   );
   mhi_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
      .clock, .reset, .ctrl, .sample(in_y_ff), .span_threshold(thr_ff),
      .bias_alpha(alpha_ff), .span_ok(span_y), .result(res_y)
   );
   mhi_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_z (
      .clock, .reset, .ctrl, .sample(in_z_ff), .span_threshold(thr_ff),
      .bias_alpha(alpha_ff), .span_ok(span_z), .result(res_z)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= SPAN_THRESHOLD_RST;
         alpha_ff <= BIAS_ALPHA_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPAN_THRESHOLD: begin
               thr_ff <= csr_wdata;
            end
            CSR_BIAS_ALPHA: begin
               alpha_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_x_ff <= req_if.mag_x;
         in_y_ff <= req_if.mag_y;
         in_z_ff <= req_if.mag_z;
      end
   end

   // result register and calibration flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         calib_ff     <= 1'b0;
      end else begin
         if (stage_go) begin
            rsp_valid_ff <= 1'b1;
            calib_ff     <= calib_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go) begin
         out_x_ff   <= res_x;
         out_y_ff   <= res_y;
         out_z_ff   <= res_z;
         cal_out_ff <= calib_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_x      = out_x_ff;
   assign rsp_if.out_y      = out_y_ff;
   assign rsp_if.out_z      = out_z_ff;
   assign rsp_if.calibrated = cal_out_ff;

   a_calib_sticky: assert property (@(posedge clock) disable iff (reset)
      calib_ff |=> calib_ff)
      else $error("calibration flag dropped");

   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      stage_go |=> rsp_valid_ff)
      else $error("processed item not presented");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !stage_go) |=> (in_valid_ff && $stable(in_x_ff)))
      else $error("pending item lost");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      stage_go |=> (cal_out_ff == calib_ff))
      else $error("result flag disagrees with state");

endmodule

`default_nettype wire
